// ===== hdl/fata_pkg.sv =====
// ----------------------------------------------------------------------------
// fata_pkg: shared constants and types for the fast atan2 block
// Fixed-point formats, coefficients, pipeline stage map and side-band record.
// ----------------------------------------------------------------------------
package fata_pkg;

  // field widths
  localparam int IN_WIDTH       = 16;
  localparam int ANGLE_FRAC     = 13;
  localparam int ANGLE_WIDTH    = ANGLE_FRAC + 3;
  localparam int IN_DATA_WIDTH  = ((2 * IN_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((ANGLE_WIDTH + 7) / 8) * 8;

  // ratio magnitude is unsigned Q1.15, quotient magnitude reaches 2^15
  localparam int RATIO_FRAC = 15;
  localparam int QUO_WIDTH  = RATIO_FRAC + 1;
  localparam int SUM_WIDTH  = 15;

  // pipeline stage map
  localparam int S_ABS      = 0;
  localparam int S_CMP      = 1;
  localparam int DIV_FIRST  = 2;
  localparam int S_POLY1    = DIV_FIRST + QUO_WIDTH;
  localparam int S_POLY2    = S_POLY1 + 1;
  localparam int S_PROD     = S_POLY2 + 1;
  localparam int S_OUT      = S_PROD + 1;
  localparam int NUM_STAGES = S_OUT + 1;

  // polynomial coefficients in Q0.15 and pi/4 in Q1.15
  localparam logic [SUM_WIDTH-1:0] COEF_A     = SUM_WIDTH'(8018);
  localparam logic [SUM_WIDTH-1:0] COEF_B     = SUM_WIDTH'(2173);
  localparam logic [QUO_WIDTH-1:0] QUARTER_PI = QUO_WIDTH'(25736);
  localparam logic [QUO_WIDTH-1:0] RATIO_ONE  = QUO_WIDTH'(2 ** RATIO_FRAC);
  localparam logic [QUO_WIDTH-1:0] RATIO_MAX  = QUO_WIDTH'(2 ** RATIO_FRAC - 1);

  // pi and pi/2 rounded to nearest in the angle format
  localparam logic [63:0] PI_Q60    = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_FULL   =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC))) >> (60 - ANGLE_FRAC);
  localparam logic [63:0] HALF_FULL =
    (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC))) >> (61 - ANGLE_FRAC);
  localparam logic [ANGLE_WIDTH-1:0] PI_Q      = PI_FULL[ANGLE_WIDTH-1:0];
  localparam logic [ANGLE_WIDTH-1:0] HALF_PI_Q = HALF_FULL[ANGLE_WIDTH-1:0];

  // per-item flags that ride along with the data
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic swap;   // x/y branch taken
    logic zero;   // zero vector
    logic neg;    // ratio is negative
  } side_t;

endpackage

// ===== hdl/fast_atan2_approx.sv =====
// ----------------------------------------------------------------------------
// fast_atan2_approx: pipelined fixed-point atan2
// Vector (x, y) in, angle in signed Q3.13 radians out, one transfer per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel carries one vector per transfer, m_* channel one angle.
//   The ratio of the smaller to the larger magnitude comes from a restoring
//   divider with one quotient bit per stage (16 stages), followed by three
//   polynomial stages and a quadrant correction stage.
//   Throughput: one item per cycle while the receiver keeps m_tready high.
//   Every stage carries its own valid bit; a stage loads when it is empty or
//   when the stage after it moves on, so bubbles are squeezed out and input
//   is still taken while a finished angle waits at the output.
//   When the receiver stalls, the pipeline fills up and s_tready drops once
//   every stage holds an item; nothing is dropped or repeated.
//   Reset (rst, synchronous) clears all valid bits; data registers keep
//   whatever they hold.
//   The zero vector gives angle 0.
// ----------------------------------------------------------------------------
module fast_atan2_approx (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // fields from bit 0: x_component[15:0], y_component[15:0]
  input  logic [fata_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // fields from bit 0: angle[15:0]
  output logic [fata_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

  localparam int IW  = fata_pkg::IN_WIDTH;
  localparam int AW  = fata_pkg::ANGLE_WIDTH;
  localparam int QW  = fata_pkg::QUO_WIDTH;
  localparam int SW  = fata_pkg::SUM_WIDTH;
  localparam int RF  = fata_pkg::RATIO_FRAC;
  localparam int NS  = fata_pkg::NUM_STAGES;
  localparam int MSH = 30 - fata_pkg::ANGLE_FRAC;

  // stage valid bits and load enables
  logic [NS-1:0] vld;
  logic [NS:0]   load;

  // occupancy chain: a stage loads when empty or when its successor loads
  always_comb begin
    load[NS] = m_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign s_tready = load[0];
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: magnitudes and signs
  logic [IW-1:0] in_x;
  logic [IW-1:0] in_y;
  logic [IW-1:0] ab_x;
  logic [IW-1:0] ab_y;
  logic          ab_xs;
  logic          ab_ys;

  assign in_x = s_tdata[IW-1:0];
  assign in_y = s_tdata[2*IW-1:IW];

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_ABS]) begin
      ab_x  <= in_x[IW-1] ? (~in_x + IW'(1)) : in_x;
      ab_y  <= in_y[IW-1] ? (~in_y + IW'(1)) : in_y;
      ab_xs <= in_x[IW-1];
      ab_ys <= in_y[IW-1];
    end
  end

  // divider register chain, index 0 is the compare stage
  logic [IW-1:0]         dv_rem  [QW+1];
  logic [IW-1:0]         dv_den  [QW+1];
  logic [QW-1:0]         dv_quo  [QW+1];
  fata_pkg::side_t       dv_side [QW+1];

  // stage 1: branch select, numerator and denominator
  logic cmp_swap;
  assign cmp_swap = !(ab_x > ab_y);

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_CMP]) begin
      dv_rem[0]        <= cmp_swap ? ab_x : ab_y;
      dv_den[0]        <= cmp_swap ? ab_y : ab_x;
      dv_quo[0]        <= '0;
      dv_side[0].x_neg <= ab_xs;
      dv_side[0].y_neg <= ab_ys;
      dv_side[0].swap  <= cmp_swap;
      dv_side[0].zero  <= cmp_swap ? (ab_y == '0) : (ab_x == '0);
      dv_side[0].neg   <= ab_xs ^ ab_ys;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [IW:0] sh;
    logic [IW:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign sh = {1'b0, dv_rem[k]};
    end else begin : g_next
      assign sh = {dv_rem[k], 1'b0};
    end

    assign diff = sh - {1'b0, dv_den[k]};
    assign ge   = (sh >= {1'b0, dv_den[k]});

    always_ff @(posedge clk) begin
      if (load[fata_pkg::DIV_FIRST+k]) begin
        dv_rem[k+1]  <= ge ? diff[IW-1:0] : sh[IW-1:0];
        dv_den[k+1]  <= dv_den[k];
        dv_quo[k+1]  <= {dv_quo[k][QW-2:0], ge};
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // poly stage 1: saturate ratio, s = C1 + C2*a
  logic [QW-1:0]    p1_a_in;
  logic [QW+SW-1:0] p1_prod;
  logic [QW-1:0]    p1_a;
  logic [SW-1:0]    p1_s;
  fata_pkg::side_t  p1_side;

  assign p1_a_in = (!dv_side[QW].neg && dv_quo[QW][QW-1]) ? fata_pkg::RATIO_MAX
                                                          : dv_quo[QW];
  assign p1_prod = fata_pkg::COEF_B * p1_a_in;

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_POLY1]) begin
      p1_a    <= p1_a_in;
      p1_s    <= fata_pkg::COEF_A + p1_prod[RF +: SW];
      p1_side <= dv_side[QW];
    end
  end

  // poly stage 2: t = (1 - a) * s
  logic [QW-1:0]    p2_comp;
  logic [QW+SW-1:0] p2_prod;
  logic [QW-1:0]    p2_a;
  logic [SW-1:0]    p2_t;
  fata_pkg::side_t  p2_side;

  assign p2_comp = fata_pkg::RATIO_ONE - p1_a;
  assign p2_prod = p2_comp * p1_s;

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_POLY2]) begin
      p2_a    <= p1_a;
      p2_t    <= p2_prod[RF +: SW];
      p2_side <= p1_side;
    end
  end

  // poly stage 3: magnitude = a * (pi/4 + t)
  logic [QW:0]     p3_p;
  logic [2*QW:0]   p3_prod;
  logic [AW-1:0]   p3_mag;
  fata_pkg::side_t p3_side;

  assign p3_p    = {1'b0, fata_pkg::QUARTER_PI} + {{(QW + 1 - SW){1'b0}}, p2_t};
  assign p3_prod = p2_a * p3_p;

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_PROD]) begin
      p3_mag  <= p3_prod[MSH +: AW];
      p3_side <= p2_side;
    end
  end

  // output stage: sign and quadrant correction
  logic [AW-1:0] oc_at;
  logic [AW-1:0] angle_next;
  logic [AW-1:0] angle;

  assign oc_at = p3_side.neg ? (~p3_mag + AW'(1)) : p3_mag;

  always_comb begin
    priority if (p3_side.zero) begin
      angle_next = '0;
    end else if (p3_side.swap) begin
      angle_next = p3_side.y_neg ? (~fata_pkg::HALF_PI_Q + AW'(1) - oc_at)
                                 : (fata_pkg::HALF_PI_Q - oc_at);
    end else if (p3_side.x_neg) begin
      angle_next = p3_side.y_neg ? (oc_at - fata_pkg::PI_Q)
                                 : (oc_at + fata_pkg::PI_Q);
    end else begin
      angle_next = oc_at;
    end
  end

  always_ff @(posedge clk) begin
    if (load[fata_pkg::S_OUT]) begin
      angle <= angle_next;
    end
  end

  assign m_tdata = fata_pkg::OUT_DATA_WIDTH'(angle);

endmodule
